FILE: rtl/itfcc_pkg.sv
// shared constants, types and color coefficients of the iso threshold contour block
package itfcc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int COORD_W     = 10;
    localparam int GEOM_W      = 11;
    localparam int CMP_W       = (ADDR_W + 1 > GEOM_W) ? ADDR_W + 1 : GEOM_W;
    localparam int THR_W       = 16;
    localparam int RECIP_W     = 24;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int COLOR_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECIPROCAL   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd3;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 16'd2048;
    localparam logic [RECIP_W-1:0] RECIPROCAL_RESET = 24'd8192;
    localparam logic [GEOM_W-1:0]  WIDTH_RESET      = 11'd1024;
    localparam logic [GEOM_W-1:0]  HEIGHT_RESET     = 11'd1024;

    // ratio and color arithmetic
    localparam int PROD_W     = SAMPLE_BITS + RECIP_W;
    localparam int FRAC_BITS  = 12;
    localparam int RQ_W       = PROD_W + 1 - FRAC_BITS;
    localparam int RATIO_W    = 14;
    localparam int T_W        = 13;
    localparam int RATIO_HALF = 2048;
    localparam int RATIO_ONE  = 4096;
    localparam int RATIO_MAX  = 8192;
    localparam int CH_NUM     = 3;
    localparam int COEF_W     = 10;
    localparam int N_W        = 22;
    localparam int X_W        = N_W + 8;
    localparam int Y_W        = X_W - FRAC_BITS;
    localparam int ROUND_CH   = 2048000;
    localparam int DIV_W      = 19;
    localparam int DIV_SHIFT  = 28;
    localparam int Q_W        = Y_W + DIV_W;
    localparam logic [DIV_W-1:0]   DIV_RECIP = 19'd268436;
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;

    // coefficients in thousandths, index 0 red, 1 green, 2 blue
    localparam logic [CH_NUM-1:0][COEF_W-1:0] IN_BASE   = {10'd80,  10'd380, 10'd950};
    localparam logic [CH_NUM-1:0][COEF_W-1:0] IN_SLOPE  = {10'd180, 10'd480, 10'd0};
    localparam logic [CH_NUM-1:0][COEF_W-1:0] OUT_BASE  = {10'd100, 10'd40,  10'd15};
    localparam logic [CH_NUM-1:0][COEF_W-1:0] OUT_SLOPE = {10'd680, 10'd420, 10'd50};

    typedef logic [1:0] job_kind_t;
    localparam job_kind_t JOB_UPPER = 2'd0;
    localparam job_kind_t JOB_LEFT  = 2'd1;
    localparam job_kind_t JOB_SELF  = 2'd2;

    typedef struct packed {
        logic      accept;
        logic      rd_en;
        logic      rd_right;
        logic      cap_up;
        logic      cap_right;
        logic      wr_en;
        logic      job_start;
        job_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic y_nz;
        logic x_nz;
        logic x_last;
        logic last_row;
        logic job_free;
    } dp_status_t;

endpackage

FILE: rtl/itfcc_ram.sv
// generic single write port ram with registered read
module itfcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/itfcc_ctrl.sv
// controller: sequences line store access and pixel jobs for each item
module itfcc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  itfcc_pkg::dp_status_t status,
    output itfcc_pkg::dp_cmd_t    cmd
);
    import itfcc_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_FETCH    = 3'd1;
    localparam logic [2:0] ST_RD_R     = 3'd2;
    localparam logic [2:0] ST_CAP_R    = 3'd3;
    localparam logic [2:0] ST_JOB_UP   = 3'd4;
    localparam logic [2:0] ST_JOB_LEFT = 3'd5;
    localparam logic [2:0] ST_JOB_SELF = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] tail_state;

    // what follows once the upper pixel is handled
    always_comb begin
        if (status.last_row && status.x_nz) begin
            tail_state = ST_JOB_LEFT;
        end else if (status.last_row && status.x_last) begin
            tail_state = ST_JOB_SELF;
        end else begin
            tail_state = ST_IDLE;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.kind   = JOB_UPPER;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (status.y_nz) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_RD_R;
                end else begin
                    cmd.wr_en  = 1'b1;
                    state_next = tail_state;
                end
            end
            ST_RD_R: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_right = 1'b1;
                cmd.cap_up   = 1'b1;
                state_next   = ST_CAP_R;
            end
            ST_CAP_R: begin
                cmd.cap_right = 1'b1;
                cmd.wr_en     = 1'b1;
                state_next    = ST_JOB_UP;
            end
            ST_JOB_UP: begin
                if (status.job_free) begin
                    cmd.job_start = 1'b1;
                    cmd.kind      = JOB_UPPER;
                    state_next    = tail_state;
                end
            end
            ST_JOB_LEFT: begin
                if (status.job_free) begin
                    cmd.job_start = 1'b1;
                    cmd.kind      = JOB_LEFT;
                    state_next    = status.x_last ? ST_JOB_SELF : ST_IDLE;
                end
            end
            ST_JOB_SELF: begin
                if (status.job_free) begin
                    cmd.job_start = 1'b1;
                    cmd.kind      = JOB_SELF;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/itfcc_dp.sv
// datapath: config registers, raster counters, line store and color pipeline
module itfcc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [itfcc_pkg::SAMPLE_BITS-1:0]   s_sample,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [itfcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [itfcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [itfcc_pkg::COLOR_W-1:0]       m_red,
    output logic [itfcc_pkg::COLOR_W-1:0]       m_green,
    output logic [itfcc_pkg::COLOR_W-1:0]       m_blue,
    output logic                                m_on_contour,
    output logic [itfcc_pkg::COORD_W-1:0]       m_column,
    output logic [itfcc_pkg::COORD_W-1:0]       m_row,
    output logic                                m_last_of_run,
    output logic                                m_end_of_image,
    input  itfcc_pkg::dp_cmd_t                  cmd,
    output itfcc_pkg::dp_status_t               status
);
    import itfcc_pkg::*;

    typedef struct packed {
        logic              contour;
        logic [ADDR_W-1:0] x;
        logic [ROW_W-1:0]  y;
        logic              eoi;
        logic              last;
    } pix_tag_t;

    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;
    logic [GEOM_W-1:0]  width_reg, width_next;
    logic [GEOM_W-1:0]  height_reg, height_next;
    logic [ADDR_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SAMPLE_BITS-1:0] prev_reg;

    logic [SAMPLE_BITS-1:0] cur_reg, left_reg, up_reg, right_reg;
    logic [ADDR_W-1:0]      x_reg;
    logic [ROW_W-1:0]       y_reg;

    logic [CMP_W-1:0]  w_eff;
    logic [GEOM_W-1:0] h_eff;
    logic              pos_ok, in_x_last, in_last_row, geom_wr;
    logic [ADDR_W-1:0] x_in;
    logic [ROW_W-1:0]  y_in;

    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    logic [THR_W-1:0]       thr_eff;
    logic [SAMPLE_BITS-1:0] jv, jrv, jbv;
    logic                   jrchk, jbchk;
    pix_tag_t               tag0;

    logic                   v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic [PROD_W-1:0]      prod1_reg;
    logic                   inside1_reg;
    pix_tag_t               tag1_reg, tag2_reg, tag3_reg;

    logic [PROD_W:0]        rsum;
    logic [RQ_W-1:0]        rq;
    logic [RATIO_W-1:0]     ratio;
    logic [T_W-1:0]         t;
    logic [CH_NUM-1:0][N_W-1:0] n2_next, n2_reg;
    logic [CH_NUM-1:0][Q_W-1:0] q3_next, q3_reg;
    logic [CH_NUM-1:0][X_W-1:0] x_sum;

    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    pix_tag_t           out_tag_reg;

    function automatic logic crosses(input logic [SAMPLE_BITS-1:0] a,
                                     input logic [SAMPLE_BITS-1:0] b,
                                     input logic [THR_W-1:0] thr);
        return (a == thr) || (b == thr) || ((a > thr) != (b > thr));
    endfunction

    // configuration
    assign cfg_ready = 1'b1;
    assign geom_wr   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
                                     cfg_index == REG_IMAGE_HEIGHT);

    always_comb begin
        thr_next    = thr_reg;
        recip_next  = recip_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD:    thr_next    = cfg_data[THR_W-1:0];
                REG_RECIPROCAL:   recip_next  = cfg_data[RECIP_W-1:0];
                REG_IMAGE_WIDTH:  width_next  = cfg_data[GEOM_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[GEOM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // geometry and raster position
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = GEOM_W'(1);
        end else if (height_reg > GEOM_W'(MAX_HEIGHT)) begin
            h_eff = GEOM_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        pos_ok      = (CMP_W'(col_reg) < w_eff) && (GEOM_W'(row_reg) < h_eff);
        x_in        = pos_ok ? col_reg : '0;
        y_in        = pos_ok ? row_reg : '0;
        in_x_last   = (CMP_W'(x_in) + CMP_W'(1)) >= w_eff;
        in_last_row = (GEOM_W'(y_in) + GEOM_W'(1)) >= h_eff;

        col_next = col_reg;
        row_next = row_reg;
        if (geom_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd.accept) begin
            if (in_x_last) begin
                col_next = '0;
                row_next = in_last_row ? '0 : y_in + ROW_W'(1);
            end else begin
                col_next = x_in + ADDR_W'(1);
                row_next = y_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THRESHOLD_RESET;
            recip_reg  <= RECIPROCAL_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            prev_reg   <= '0;
        end else begin
            thr_reg    <= thr_next;
            recip_reg  <= recip_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            if (cmd.accept) begin
                prev_reg <= s_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cur_reg  <= s_sample;
            left_reg <= prev_reg;
            x_reg    <= x_in;
            y_reg    <= y_in;
        end
        if (cmd.cap_up) begin
            up_reg <= rd_data;
        end
        if (cmd.cap_right) begin
            right_reg <= rd_data;
        end
    end

    // line store holding the previous row
    assign rd_addr = cmd.rd_right ? x_reg + ADDR_W'(1) : x_reg;

    itfcc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (x_reg),
        .wr_data (cur_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // status to the controller
    assign status.y_nz     = (y_reg != '0);
    assign status.x_nz     = (x_reg != '0);
    assign status.x_last   = (CMP_W'(x_reg) + CMP_W'(1)) >= w_eff;
    assign status.last_row = (GEOM_W'(y_reg) + GEOM_W'(1)) >= h_eff;
    assign status.job_free = !(v1_reg || v2_reg || v3_reg) && (!m_valid_reg || m_ready);

    // job operand selection and contour test
    assign thr_eff = (thr_reg == '0) ? THR_W'(1) : thr_reg;

    always_comb begin
        jv    = cur_reg;
        jrv   = cur_reg;
        jbv   = cur_reg;
        jrchk = 1'b0;
        jbchk = 1'b0;
        tag0  = '0;
        case (cmd.kind)
            JOB_UPPER: begin
                jv        = up_reg;
                jrv       = right_reg;
                jrchk     = !status.x_last;
                jbv       = cur_reg;
                jbchk     = 1'b1;
                tag0.x    = x_reg;
                tag0.y    = y_reg - ROW_W'(1);
                tag0.eoi  = 1'b0;
                tag0.last = !(status.last_row && (status.x_nz || status.x_last));
            end
            JOB_LEFT: begin
                jv        = left_reg;
                jrv       = cur_reg;
                jrchk     = 1'b1;
                tag0.x    = x_reg - ADDR_W'(1);
                tag0.y    = y_reg;
                tag0.eoi  = 1'b0;
                tag0.last = !status.x_last;
            end
            JOB_SELF: begin
                jv        = cur_reg;
                tag0.x    = x_reg;
                tag0.y    = y_reg;
                tag0.eoi  = 1'b1;
                tag0.last = 1'b1;
            end
            default: begin
            end
        endcase
        tag0.contour = (jrchk && crosses(jv, jrv, thr_eff)) ||
                       (jbchk && crosses(jv, jbv, thr_eff));
    end

    // color pipeline
    always_comb begin
        rsum  = {1'b0, prod1_reg} + (PROD_W + 1)'(RATIO_HALF);
        rq    = rsum[PROD_W:FRAC_BITS];
        ratio = (rq > RQ_W'(RATIO_MAX)) ? RATIO_W'(RATIO_MAX) : RATIO_W'(rq);
        if (inside1_reg) begin
            t = (ratio > RATIO_W'(RATIO_ONE)) ? T_W'(ratio - RATIO_W'(RATIO_ONE)) : '0;
        end else begin
            t = (ratio > RATIO_W'(RATIO_ONE)) ? T_W'(RATIO_ONE) : T_W'(ratio);
        end
        for (int c = 0; c < CH_NUM; c++) begin
            if (inside1_reg) begin
                n2_next[c] = {IN_BASE[c], 12'b0} + N_W'(N_W'(IN_SLOPE[c]) * N_W'(t));
            end else begin
                n2_next[c] = {OUT_BASE[c], 12'b0} + N_W'(N_W'(OUT_SLOPE[c]) * N_W'(t));
            end
        end
        for (int c = 0; c < CH_NUM; c++) begin
            x_sum[c]   = {n2_reg[c], 8'b0} - X_W'(n2_reg[c]) + X_W'(ROUND_CH);
            q3_next[c] = Q_W'(x_sum[c][X_W-1:FRAC_BITS]) * Q_W'(DIV_RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.job_start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.job_start) begin
            prod1_reg   <= PROD_W'(PROD_W'(jv) * PROD_W'(recip_reg));
            inside1_reg <= (jv >= thr_eff);
            tag1_reg    <= tag0;
        end
        n2_reg   <= n2_next;
        tag2_reg <= tag1_reg;
        q3_reg   <= q3_next;
        tag3_reg <= tag2_reg;
        if (v3_reg) begin
            red_reg     <= tag3_reg.contour ? COLOR_MAX : q3_reg[0][DIV_SHIFT +: COLOR_W];
            green_reg   <= tag3_reg.contour ? COLOR_MAX : q3_reg[1][DIV_SHIFT +: COLOR_W];
            blue_reg    <= tag3_reg.contour ? COLOR_MAX : q3_reg[2][DIV_SHIFT +: COLOR_W];
            out_tag_reg <= tag3_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_on_contour   = out_tag_reg.contour;
    assign m_column       = COORD_W'(out_tag_reg.x);
    assign m_row          = COORD_W'(out_tag_reg.y);
    assign m_last_of_run  = out_tag_reg.last;
    assign m_end_of_image = out_tag_reg.eoi;

endmodule

FILE: rtl/iso_threshold_false_color_contour.sv
// top level of the iso threshold false color contour renderer
// Q4.12 field samples enter in raster order and leave as colored pixels one row late:
// sample (x,y) releases pixel (x,y-1), and on the bottom row also (x-1,y) and, at the
// right edge, (x,y), upper pixel first. Contour pixels are white. Registers are to be written
// through the cfg channel only while the block is idle; the block itself does not enforce this.
// Writing width or height restarts the frame at (0,0). An item below the top row reads the
// upper and right samples in turn through the single read port of the line store, and the
// four-stage color pipeline holds one pixel at a time, so a pixel job waits until the
// pipeline is empty and the output is not stalled. The line store needs no clearing
// after reset.
module iso_threshold_false_color_contour (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [itfcc_pkg::SAMPLE_BITS-1:0]   s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [itfcc_pkg::COLOR_W-1:0]       m_red,
    output logic [itfcc_pkg::COLOR_W-1:0]       m_green,
    output logic [itfcc_pkg::COLOR_W-1:0]       m_blue,
    output logic                                m_on_contour,
    output logic [itfcc_pkg::COORD_W-1:0]       m_column,
    output logic [itfcc_pkg::COORD_W-1:0]       m_row,
    output logic                                m_last_of_run,
    output logic                                m_end_of_image,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [itfcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [itfcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import itfcc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    itfcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itfcc_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_sample       (s_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_on_contour   (m_on_contour),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_image (m_end_of_image),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

FILE: rtl/itfcc_checker.sv
// port-level checks of the contour renderer, bound to the top level
module itfcc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [itfcc_pkg::COLOR_W-1:0]       m_red,
    input logic [itfcc_pkg::COLOR_W-1:0]       m_green,
    input logic [itfcc_pkg::COLOR_W-1:0]       m_blue,
    input logic                                m_on_contour,
    input logic [itfcc_pkg::COORD_W-1:0]       m_column,
    input logic [itfcc_pkg::COORD_W-1:0]       m_row,
    input logic                                m_last_of_run,
    input logic                                m_end_of_image
);
    import itfcc_pkg::*;

    // stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green) &&
        $stable(m_blue) && $stable(m_column) && $stable(m_row) &&
        $stable(m_on_contour) && $stable(m_last_of_run) && $stable(m_end_of_image))
        else $error("output item changed while stalled");

    // contour pixels are white
    a_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_on_contour |-> m_red == COLOR_MAX && m_green == COLOR_MAX &&
        m_blue == COLOR_MAX)
        else $error("contour pixel not white");

    // bottom-right pixel closes its run and has no neighbors to cross
    a_eoi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_image |-> m_last_of_run && !m_on_contour)
        else $error("end of image item malformed");

    // no item right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind iso_threshold_false_color_contour itfcc_checker u_itfcc_checker (.*);

FILE: tb/iso_threshold_false_color_contour_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the iso threshold false color contour renderer
module iso_threshold_false_color_contour_test;
    import itfcc_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hF6;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               on_contour;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_of_run;
        logic               end_of_image;
    } pixel_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [SAMPLE_BITS-1:0] s_sample  = '0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic [COLOR_W-1:0]     m_red;
    logic [COLOR_W-1:0]     m_green;
    logic [COLOR_W-1:0]     m_blue;
    logic                   m_on_contour;
    logic [COORD_W-1:0]     m_column;
    logic [COORD_W-1:0]     m_row;
    logic                   m_last_of_run;
    logic                   m_end_of_image;
    logic                   cfg_ready;

    // predictor state
    logic [SAMPLE_BITS-1:0] line_store [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] left_sample   = '0;
    int unsigned            col_count     = 0;
    int unsigned            row_count     = 0;
    logic [THR_W-1:0]       cur_threshold = THRESHOLD_RESET;
    logic [RECIP_W-1:0]     cur_recip     = RECIPROCAL_RESET;
    logic [GEOM_W-1:0]      cur_width     = WIDTH_RESET;
    logic [GEOM_W-1:0]      cur_height    = HEIGHT_RESET;

    pixel_t                 expected_pixels [$];
    logic [SAMPLE_BITS-1:0] pending_samples [$];
    pixel_t                 seen_pixel;
    pixel_t                 want_pixel;
    int                     send_idle_pct   = 0;
    int                     recv_stall_pct  = 0;
    int                     ready_hold_len  = 0;
    int                     ready_hold_left = 0;
    int                     errors          = 0;
    int                     cycle_count     = 0;

    iso_threshold_false_color_contour dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_on_contour   (m_on_contour),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_image (m_end_of_image),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [COLOR_W-1:0] ramp(int unsigned base, int unsigned slope,
                                                int unsigned t);
        longint unsigned num;
        num = 64'd255 * (64'(base) * 64'd4096 + 64'(slope) * 64'(t));
        return COLOR_W'((num + 64'd2048000) / 64'd4096000);
    endfunction

    function automatic bit straddles(logic [THR_W-1:0] a, logic [THR_W-1:0] b,
                                     logic [THR_W-1:0] thr);
        return a == thr || b == thr || ((a > thr) != (b > thr));
    endfunction

    function automatic pixel_t shade(logic [SAMPLE_BITS-1:0] v, bit has_right,
                                     logic [SAMPLE_BITS-1:0] rv, bit has_below,
                                     logic [SAMPLE_BITS-1:0] bv, int unsigned x,
                                     int unsigned y, bit eoi);
        pixel_t           p;
        logic [THR_W-1:0] thr;
        longint unsigned  wide;
        int unsigned      ratio;
        int unsigned      t;
        bit               contour;
        thr = (cur_threshold == 0) ? 16'd1 : cur_threshold;
        wide = (64'(v) * 64'(cur_recip) + 64'd2048) >> 12;
        ratio = (wide > 64'd8192) ? 8192 : 32'(wide);
        if (v >= thr) begin
            t = (ratio > 4096) ? ratio - 4096 : 0;
            p.red   = ramp(950, 0, t);
            p.green = ramp(380, 480, t);
            p.blue  = ramp(80, 180, t);
        end else begin
            t = (ratio > 4096) ? 4096 : ratio;
            p.red   = ramp(15, 50, t);
            p.green = ramp(40, 420, t);
            p.blue  = ramp(100, 680, t);
        end
        contour = has_right && straddles(v, rv, thr);
        if (!contour && has_below) begin
            contour = straddles(v, bv, thr);
        end
        if (contour) begin
            p.red   = COLOR_MAX;
            p.green = COLOR_MAX;
            p.blue  = COLOR_MAX;
        end
        p.on_contour   = contour;
        p.column       = COORD_W'(x);
        p.row          = COORD_W'(y);
        p.last_of_run  = 1'b0;
        p.end_of_image = eoi;
        return p;
    endfunction

    function automatic void predict_pixels(logic [SAMPLE_BITS-1:0] v);
        pixel_t      run [3];
        int          n;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        bit          last_row;
        bit          has_right;
        n = 0;
        w = (cur_width == 0) ? 1 : cur_width;
        h = (cur_height == 0) ? 1 : cur_height;
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        if (h > MAX_HEIGHT) begin
            h = MAX_HEIGHT;
        end
        x = col_count;
        y = row_count;
        if (x >= w || y >= h) begin
            x = 0;
            y = 0;
        end
        last_row = (y + 1 >= h);
        if (y > 0) begin
            has_right = (x + 1 < w);
            run[n] = shade(line_store[x], has_right, has_right ? line_store[x + 1] : 16'd0,
                           1'b1, v, x, y - 1, 1'b0);
            n++;
        end
        line_store[x] = v;
        if (last_row) begin
            if (x > 0) begin
                run[n] = shade(left_sample, 1'b1, v, 1'b0, 16'd0, x - 1, y, 1'b0);
                n++;
            end
            if (x + 1 >= w) begin
                run[n] = shade(v, 1'b0, 16'd0, 1'b0, 16'd0, x, y, 1'b1);
                n++;
            end
        end
        left_sample = v;
        if (x + 1 >= w) begin
            col_count = 0;
            row_count = last_row ? 0 : y + 1;
        end else begin
            col_count = x + 1;
            row_count = y;
        end
        if (n > 0) begin
            run[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_pixels.push_back(run[i]);
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] field_sample(logic [THR_W-1:0] thr);
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return thr;
            3, 4, 5: return thr + 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // sample driver, predicts on each accepted item
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_pixels(s_sample);
        end
        if (!s_valid || s_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid  <= 1'b1;
                s_sample <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // pixel receiver with random stalls and long hold-offs
    always @(posedge aclk) begin
        if (ready_hold_len != 0) begin
            ready_hold_left = ready_hold_len;
            ready_hold_len  = 0;
        end
        if (ready_hold_left != 0) begin
            ready_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_pixel = {m_red, m_green, m_blue, m_on_contour, m_column, m_row,
                          m_last_of_run, m_end_of_image};
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual %h", $time, seen_pixel);
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (seen_pixel !== want_pixel) begin
                    errors++;
                    $display("%0t: pixel mismatch, expected rgb %h %h %h c%0b (%0d,%0d) l%0b e%0b",
                             $time, want_pixel.red, want_pixel.green, want_pixel.blue,
                             want_pixel.on_contour, want_pixel.column, want_pixel.row,
                             want_pixel.last_of_run, want_pixel.end_of_image);
                    $display("%0t:   actual rgb %h %h %h c%0b (%0d,%0d) l%0b e%0b",
                             $time, seen_pixel.red, seen_pixel.green, seen_pixel.blue,
                             seen_pixel.on_contour, seen_pixel.column, seen_pixel.row,
                             seen_pixel.last_of_run, seen_pixel.end_of_image);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_sample(logic [SAMPLE_BITS-1:0] v);
        while (pending_samples.size() >= 2) @(posedge aclk);
        pending_samples.push_back(v);
    endtask

    // wait on the clock and recheck, so an item popped at this edge is seen as valid
    task automatic wait_idle();
        do begin
            while (pending_samples.size() != 0 || s_valid || expected_pixels.size() != 0)
                @(posedge aclk);
            @(posedge aclk);
        end while (pending_samples.size() != 0 || s_valid || expected_pixels.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            REG_THRESHOLD:  cur_threshold = data[THR_W-1:0];
            REG_RECIPROCAL: cur_recip = data[RECIP_W-1:0];
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
                if (index == REG_IMAGE_WIDTH) begin
                    cur_width = data[GEOM_W-1:0];
                end else begin
                    cur_height = data[GEOM_W-1:0];
                end
                col_count = 0;
                row_count = 0;
            end
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [THR_W-1:0] thr, logic [RECIP_W-1:0] recip,
                             logic [GEOM_W-1:0] w, logic [GEOM_W-1:0] h);
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_RECIPROCAL, recip);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // reset geometry keeps these items on the top row
    task automatic test_reset_defaults();
        repeat (5) send_sample(field_sample(THRESHOLD_RESET));
    endtask

    task automatic test_directed();
        logic [SAMPLE_BITS-1:0] grid [12] = '{16'h0000, 16'hFFFF, 16'h0800, 16'h07FF,
                                              16'h0801, 16'h1000, 16'h0400, 16'h0800,
                                              16'h0C00, 16'h0000, 16'hFFFF, 16'h0801};
        write_reg(REG_IMAGE_WIDTH, 24'd4);
        write_reg(REG_IMAGE_HEIGHT, 24'd3);
        foreach (grid[i]) send_sample(grid[i]);
        write_reg(REG_IMAGE_WIDTH, 24'd1);
        write_reg(REG_IMAGE_HEIGHT, 24'd1);
        send_sample(16'h0800);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
    endtask

    task automatic test_register_extremes();
        configure(16'h0000, 24'h000000, 11'd0, 11'd0);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        write_reg(REG_IMAGE_WIDTH, 24'd3);
        write_reg(REG_IMAGE_HEIGHT, 24'd2);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h0002);
        send_sample(16'h0001);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        configure(16'hFFFF, 24'hFFFFFF, 11'd3, 11'd2);
        repeat (6) send_sample(field_sample(16'hFFFF));
        write_reg(REG_UNUSED, 24'hFFFFFF);
        repeat (6) send_sample(field_sample(16'hFFFF));
    endtask

    task automatic test_max_geometry();
        configure(16'h1000, 24'h001000, 11'd2047, 11'd1);
        repeat (6) send_sample(field_sample(16'h1000));
        write_reg(REG_IMAGE_WIDTH, 24'd1);
        write_reg(REG_IMAGE_HEIGHT, 24'd2047);
        repeat (6) send_sample(field_sample(16'h1000));
    endtask

    task automatic test_backpressure();
        configure(16'h2000, 24'h000800, 11'd5, 11'd4);
        ready_hold_len = 400;
        repeat (20) send_sample(field_sample(16'h2000));
        wait_idle();
        repeat (10) send_sample(field_sample(16'h2000));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        logic [THR_W-1:0]   thr;
        logic [RECIP_W-1:0] recip;
        logic [GEOM_W-1:0]  w;
        logic [GEOM_W-1:0]  h;
        for (int k = 0; k < 2; k++) begin
            thr = 16'($urandom_range(1, 65535));
            if ($urandom_range(3) == 0) begin
                recip = 24'($urandom);
            end else begin
                recip = (thr == 1) ? 24'hFFFFFF : 24'((32'd1 << 24) / thr);
            end
            w = ($urandom_range(9) == 0) ? 11'($urandom_range(7, 24)) : 11'($urandom_range(1, 5));
            h = 11'($urandom_range(1, 4));
            configure(thr, recip, w, h);
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            repeat (12) send_sample(field_sample(thr));
            wait_idle();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed();
        test_register_extremes();
        test_max_geometry();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(78, 0);
        test_random_phase(0, 78);
        test_random_phase(29, 29);
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
